// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the pan sharpen unit RTL.
// Depends on nothing; each user supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// plain invariant
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

// ===== hw/rtl/lrps_pkg.sv =====
// Package for the local regression pan sharpen unit.
// Register indexes, reset values and default parameters; no dependencies.
package lrps_pkg;
    localparam int DEF_WINDOW      = 5;
    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int DEF_BANDS       = 4;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [2:0] CFG_LINE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_BAND_COUNT  = 3'd1;
    localparam logic [2:0] CFG_ATTENUATOR  = 3'd2;
    localparam logic [2:0] CFG_SLOPE_CLAMP = 3'd3;
    localparam logic [2:0] CFG_PAN_NULL    = 3'd4;
    localparam logic [2:0] CFG_COLOR_NULL  = 3'd5;
    localparam logic [2:0] CFG_BAND_FLOORS = 3'd6;

    localparam logic [11:0] RST_LINE_WIDTH  = 12'd2048;
    localparam logic [2:0]  RST_BAND_COUNT  = 3'd3;
    localparam logic [15:0] RST_ATTENUATOR  = 16'd4096;
    localparam logic [15:0] RST_SLOPE_CLAMP = 16'd1024;
endpackage

// ===== hw/rtl/local_regression_pan_sharpen_unit.sv =====
// Local regression pan sharpen unit: line stores, window, per-band fit.
// Per pixel: line store reads, a wait, then a window shift; with a result, each band is
// skipped or fitted (window scan, two multiplies, denominator and, where the fit holds,
// bit-serial divide, slope, product and result), then the output register is loaded.
// One pixel at a time; the shared bit-serial divider and window scan set the rate.
// rst_n asynchronous active low clears configuration, control, counters and window;
// line store memories and datapath registers are not cleared.
`include "assert_macros.svh"
module local_regression_pan_sharpen_unit
    import lrps_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int BANDS       = DEF_BANDS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        frame_start,
    input  logic [15:0] pan_low,
    input  logic [15:0] pan_high,
    input  logic [15:0] band_0,
    input  logic [15:0] band_1,
    input  logic [15:0] band_2,
    input  logic [15:0] band_3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] out_col,
    output logic [11:0] out_row,
    output logic [15:0] out_band_0,
    output logic [15:0] out_band_1,
    output logic [15:0] out_band_2,
    output logic [15:0] out_band_3,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int HALF  = WINDOW / 2;
    localparam int LINES = WINDOW - 1;
    localparam int WW    = WINDOW * WINDOW;
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int LW    = $clog2(LINES);
    localparam int AW    = $clog2(LINES * MAX_WIDTH);
    localparam int PTW   = $clog2(WW);
    localparam int NW    = $clog2(WW + 1);
    localparam int SXW   = 16 + NW;
    localparam int SQW   = 32 + NW;
    localparam int PW    = 32 + 2 * NW;
    localparam int NUMW  = PW + 1;
    localparam int DIVW  = NUMW + 8;
    localparam int DCW   = $clog2(DIVW);
    localparam logic [15:0] SMAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_BAND  = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_MUL1  = 4'd6;
    localparam logic [3:0] S_MUL2  = 4'd7;
    localparam logic [3:0] S_DEN   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_SLOPE = 4'd10;
    localparam logic [3:0] S_PROD  = 4'd11;
    localparam logic [3:0] S_RES   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    // configuration
    logic [11:0] line_width_reg;
    logic [2:0]  band_count_reg;
    logic [15:0] attenuator_reg, slope_clamp_reg, pan_null_reg, color_null_reg;
    logic [63:0] band_floors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= RST_LINE_WIDTH;
            band_count_reg  <= RST_BAND_COUNT;
            attenuator_reg  <= RST_ATTENUATOR;
            slope_clamp_reg <= RST_SLOPE_CLAMP;
            pan_null_reg    <= '0;
            color_null_reg  <= '0;
            band_floors_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:  line_width_reg  <= cfg_data[11:0];
                CFG_BAND_COUNT:  band_count_reg  <= cfg_data[2:0];
                CFG_ATTENUATOR:  attenuator_reg  <= cfg_data[15:0];
                CFG_SLOPE_CLAMP: slope_clamp_reg <= cfg_data[15:0];
                CFG_PAN_NULL:    pan_null_reg    <= cfg_data[15:0];
                CFG_COLOR_NULL:  color_null_reg  <= cfg_data[15:0];
                CFG_BAND_FLOORS: band_floors_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [12:0] eff_width;
    logic [2:0]  bands_used;
    logic [15:0] pn, cn;
    always_comb
    begin
        eff_width = {1'b0, line_width_reg};
        if (line_width_reg == 12'd0 || 13'(line_width_reg) > 13'(MAX_WIDTH))
            eff_width = 13'(MAX_WIDTH);
        bands_used = (32'(band_count_reg) > BANDS) ? 3'(BANDS) : band_count_reg;
        pn = pan_null_reg & SMAX;
        cn = color_null_reg & SMAX;
    end

    // control state
    logic [3:0]      state_reg, state_next;
    logic [COLW-1:0] col_reg;
    logic [11:0]     row_reg;
    logic [LW-1:0]   lptr_reg;
    logic [LW-1:0]   k_reg;
    logic            rd_pend_reg;
    logic [LW-1:0]   rd_k_reg;
    logic [1:0]      band_reg;
    logic [PTW-1:0]  pt_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic            out_valid_reg;

    // payload
    logic [31:0] pix_pan_reg;
    logic [63:0] pix_col_reg;
    logic [31:0] newp_reg [LINES];
    logic [63:0] newc_reg [LINES];
    logic [31:0] win_pan_reg [WW];
    logic [63:0] win_col_reg [WW];
    logic [10:0] pos_col_reg;
    logic [11:0] pos_row_reg;
    logic [15:0] res_reg [4];
    logic [NW-1:0]  n_reg;
    logic [SXW-1:0] sx_reg, sy_reg;
    logic [SQW-1:0] sxx_reg, sxy_reg;
    logic [PW-1:0]  ma_reg, mb_reg;
    logic signed [NUMW-1:0] num_reg, den_reg;
    logic [NUMW-1:0] rem_reg;
    logic [DIVW-1:0] dvd_reg;
    logic signed [32:0] p1_reg;
    logic signed [49:0] p_reg;
    logic [10:0] ocol_reg;
    logic [11:0] orow_reg;
    logic [15:0] ob_reg [4];

    // line store memories
    logic [31:0] pan_mem [LINES * MAX_WIDTH];
    logic [63:0] col_mem [LINES * MAX_WIDTH];
    logic [31:0] pan_rd;
    logic [63:0] col_rd;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [LW:0]   rline;

    always_comb
    begin
        rline = {1'b0, lptr_reg} + {1'b0, k_reg};
        if (rline >= (LW+1)'(LINES))
            rline = rline - (LW+1)'(LINES);
        mem_we = (state_reg == S_SHIFT);
        if (mem_we)
            mem_addr = AW'(AW'(lptr_reg) * AW'(MAX_WIDTH)) + AW'(col_reg);
        else
            mem_addr = AW'(AW'(rline) * AW'(MAX_WIDTH)) + AW'(col_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pan_mem[mem_addr] <= pix_pan_reg;
            col_mem[mem_addr] <= pix_col_reg;
        end
        pan_rd <= pan_mem[mem_addr];
        col_rd <= col_mem[mem_addr];
    end

    // fit datapath helpers
    logic [15:0] acc_x, acc_y, centre;
    logic        acc_take;
    logic signed [16:0] diff;
    logic [NUMW-1:0] num_abs;
    logic [NUMW:0]   rem_sh;
    logic [15:0] slope_mag;
    logic signed [16:0] slope;
    logic [49:0] p_abs;
    logic [29:0] d_mag;
    logic signed [31:0] res_s;
    logic [15:0] floorv, res_v;
    logic [31:0] cpan;

    always_comb
    begin
        acc_x = win_pan_reg[pt_reg][15:0];
        acc_y = 16'(win_col_reg[pt_reg] >> (16 * band_reg));
        acc_take = (acc_x != pn) && (acc_y != cn);
        centre = 16'(win_col_reg[HALF * WINDOW + HALF] >> (16 * band_reg));
        cpan = win_pan_reg[HALF * WINDOW + HALF];
        diff = $signed({1'b0, cpan[31:16]}) - $signed({1'b0, cpan[15:0]});
        num_abs = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
        rem_sh = {rem_reg, dvd_reg[DIVW-1]};
        slope_mag = (dvd_reg > DIVW'(slope_clamp_reg)) ? slope_clamp_reg : dvd_reg[15:0];
        slope = num_reg[NUMW-1] ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});
        p_abs = p_reg[49] ? 50'(-p_reg) : 50'(p_reg);
        d_mag = 30'((p_abs + 50'(1 << 19)) >> 20);
        res_s = p_reg[49] ? $signed({16'b0, centre}) - $signed({2'b0, d_mag})
                          : $signed({16'b0, centre}) + $signed({2'b0, d_mag});
        floorv = 16'(band_floors_reg >> (16 * band_reg));
        if (floorv > SMAX)
            floorv = SMAX;
        if (res_s > $signed({16'b0, SMAX}))
            res_v = SMAX;
        else
            res_v = res_s[15:0];
        if (res_s < $signed({16'b0, floorv}))
            res_v = floorv;
    end

    logic in_acc, out_load, emit;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign emit     = (32'(col_reg) >= LINES) && (32'(row_reg) >= LINES);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_READ;
            S_READ:  if (32'(k_reg) == LINES - 1) state_next = S_WAIT;
            S_WAIT:  state_next = S_SHIFT;
            S_SHIFT: state_next = emit ? S_BAND : S_IDLE;
            S_BAND:
            begin
                if (3'(band_reg) < bands_used && centre != 16'd0)
                    state_next = S_ACC;
                else if (band_reg == 2'd3)
                    state_next = S_OUT;
            end
            S_ACC:   if (32'(pt_reg) == WW - 1) state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_DEN;
            S_DEN:
            begin
                if (n_reg > NW'(2) && ma_reg > mb_reg)
                    state_next = S_DIV;
                else
                    state_next = (band_reg == 2'd3) ? S_OUT : S_BAND;
            end
            S_DIV:   if (dcnt_reg == '0) state_next = S_SLOPE;
            S_SLOPE: state_next = S_PROD;
            S_PROD:  state_next = S_RES;
            S_RES:   state_next = (band_reg == 2'd3) ? S_OUT : S_BAND;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            lptr_reg      <= '0;
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            rd_k_reg      <= '0;
            band_reg      <= '0;
            pt_reg        <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WW; i++)
            begin
                win_pan_reg[i] <= '0;
                win_col_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_READ);
            rd_k_reg    <= k_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg <= '0;
                    if (in_acc && frame_start)
                    begin
                        col_reg  <= '0;
                        row_reg  <= '0;
                        lptr_reg <= '0;
                    end
                end
                S_READ: k_reg <= k_reg + 1'b1;
                S_SHIFT:
                begin
                    for (int r = 0; r < WINDOW; r++)
                    begin
                        for (int k = 0; k < WINDOW - 1; k++)
                        begin
                            win_pan_reg[r*WINDOW+k] <= win_pan_reg[r*WINDOW+k+1];
                            win_col_reg[r*WINDOW+k] <= win_col_reg[r*WINDOW+k+1];
                        end
                    end
                    for (int r = 0; r < LINES; r++)
                    begin
                        win_pan_reg[r*WINDOW+WINDOW-1] <= newp_reg[r];
                        win_col_reg[r*WINDOW+WINDOW-1] <= newc_reg[r];
                    end
                    win_pan_reg[WW-1] <= pix_pan_reg;
                    win_col_reg[WW-1] <= pix_col_reg;
                    band_reg <= '0;
                    if (13'(col_reg) + 13'd1 >= eff_width)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 12'd1;
                        if (row_reg == 12'hFFF || 32'(lptr_reg) == LINES - 1)
                            lptr_reg <= '0;
                        else
                            lptr_reg <= lptr_reg + 1'b1;
                    end
                    else
                        col_reg <= col_reg + 1'b1;
                end
                S_BAND:
                begin
                    pt_reg <= '0;
                    if (!(3'(band_reg) < bands_used && centre != 16'd0))
                        band_reg <= band_reg + 2'd1;
                end
                S_ACC:   pt_reg <= pt_reg + 1'b1;
                S_DEN:
                begin
                    dcnt_reg <= DCW'(DIVW - 1);
                    if (!(n_reg > NW'(2) && ma_reg > mb_reg))
                        band_reg <= band_reg + 2'd1;
                end
                S_DIV:   dcnt_reg <= dcnt_reg - 1'b1;
                S_RES:   band_reg <= band_reg + 2'd1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_pan_reg <= {pan_high & SMAX, pan_low & SMAX};
            pix_col_reg <= {band_3 & SMAX, band_2 & SMAX, band_1 & SMAX, band_0 & SMAX};
        end
        if (rd_pend_reg)
        begin
            newp_reg[rd_k_reg] <= pan_rd;
            newc_reg[rd_k_reg] <= col_rd;
        end
        if (state_reg == S_SHIFT)
        begin
            pos_col_reg <= 11'(16'(col_reg) - 16'(HALF));
            pos_row_reg <= row_reg - 12'(HALF);
        end
        unique case (state_reg)
            S_BAND:
            begin
                n_reg   <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxx_reg <= '0;
                sxy_reg <= '0;
                res_reg[band_reg] <= 16'd0;
            end
            S_ACC:
            begin
                if (acc_take)
                begin
                    n_reg   <= n_reg + 1'b1;
                    sx_reg  <= sx_reg + SXW'(acc_x);
                    sy_reg  <= sy_reg + SXW'(acc_y);
                    sxx_reg <= sxx_reg + SQW'(acc_x * acc_x);
                    sxy_reg <= sxy_reg + SQW'(acc_x * acc_y);
                end
            end
            S_MUL1:
            begin
                ma_reg <= PW'(n_reg * sxy_reg);
                mb_reg <= PW'(sx_reg * sy_reg);
            end
            S_MUL2:
            begin
                num_reg <= $signed({1'b0, ma_reg}) - $signed({1'b0, mb_reg});
                ma_reg  <= PW'(n_reg * sxx_reg);
                mb_reg  <= PW'(sx_reg * sx_reg);
            end
            S_DEN:
            begin
                den_reg <= $signed({1'b0, ma_reg}) - $signed({1'b0, mb_reg});
                rem_reg <= '0;
                dvd_reg <= DIVW'({num_abs, 8'b0})
                         + DIVW'(NUMW'(ma_reg - mb_reg) >> 1);
                res_reg[band_reg] <= centre;
            end
            S_DIV:
            begin
                if (rem_sh >= (NUMW+1)'(den_reg))
                begin
                    rem_reg <= NUMW'(rem_sh - (NUMW+1)'(den_reg));
                    dvd_reg <= {dvd_reg[DIVW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= NUMW'(rem_sh);
                    dvd_reg <= {dvd_reg[DIVW-2:0], 1'b0};
                end
            end
            S_SLOPE: p1_reg <= $signed(attenuator_reg) * slope;
            S_PROD:  p_reg <= 50'(p1_reg * diff);
            S_RES:   res_reg[band_reg] <= res_v;
            default: ;
        endcase
        if (out_load)
        begin
            ocol_reg <= pos_col_reg;
            orow_reg <= pos_row_reg;
            for (int b = 0; b < 4; b++)
                ob_reg[b] <= res_reg[b];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_col    = ocol_reg;
    assign out_row    = orow_reg;
    assign out_band_0 = ob_reg[0];
    assign out_band_1 = ob_reg[1];
    assign out_band_2 = ob_reg[2];
    assign out_band_3 = ob_reg[3];

    `CHK_PROP(a_accept_reads, (in_acc |=> state_reg == S_READ), "accept did not start line reads")
    `CHK_PROP(a_div_den_pos, (state_reg == S_DIV |-> den_reg > 0), "divide with non-positive den")
    `CHK_ALWAYS(a_lptr_range, 32'(lptr_reg) < LINES, "line pointer out of range")
    `CHK_PROP(a_load_free, (out_load |-> !out_valid_reg || !out_stall), "result overwritten")
endmodule

// ===== test/local_regression_pan_sharpen_unit_test.sv =====
// Self-checking testbench for local_regression_pan_sharpen_unit: streams pixel frames and
// checks every fused window result against an in-bench regression predictor.
// Depends on lrps_pkg and the unit RTL only.
`timescale 1ns / 100ps

module local_regression_pan_sharpen_unit_test;
    import lrps_pkg::*;

    localparam int WIN = 5;
    localparam int HALF = WIN / 2;
    localparam int LINES = WIN - 1;
    localparam int MAXW = 2048;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;

    typedef enum int {PAT_FLAT, PAT_RAMP, PAT_NOISE} pattern_t;

    typedef struct {
        logic [10:0] col;
        logic [11:0] row;
        logic [15:0] band [4];
    } fused_t;

    typedef struct {
        int          width;
        int          bands;
        int          att;
        int          clamp;
        int          pnull;
        int          cnull;
        logic [63:0] floors;
        pattern_t    pat;
        int          pl;
        int          ph;
        int          bv;
        int          pixels;
        bit          typed;
        int          e [4];
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        frame_start = 1'b0;
    logic [15:0] pan_low = '0;
    logic [15:0] pan_high = '0;
    logic [15:0] band_0 = '0;
    logic [15:0] band_1 = '0;
    logic [15:0] band_2 = '0;
    logic [15:0] band_3 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic [15:0] out_band_0;
    logic [15:0] out_band_1;
    logic [15:0] out_band_2;
    logic [15:0] out_band_3;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    local_regression_pan_sharpen_unit i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [11:0] width_reg = RST_LINE_WIDTH;
    logic [2:0]  bands_reg = RST_BAND_COUNT;
    logic [15:0] att_reg = RST_ATTENUATOR;
    logic [15:0] clamp_reg = RST_SLOPE_CLAMP;
    logic [15:0] pnull_reg = '0;
    logic [15:0] cnull_reg = '0;
    logic [63:0] floors_reg = '0;
    logic [31:0] pan_store [LINES * MAXW];
    logic [63:0] color_store [LINES * MAXW];
    logic [31:0] win_pan [WIN][WIN];
    logic [63:0] win_color [WIN][WIN];
    int          col_cnt = 0;
    int          row_cnt = 0;

    fused_t      fused_q [$];
    bit          typed_on = 1'b0;
    int          typed_val [4];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          frames_run = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    function automatic logic [15:0] fit_band(int b, int centre, longint diff);
        longint n, sx, sy, sxx, sxy, num, den, mag, slope, p, delta, res;
        longint clampv, floorv, att, x, y;
        n = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++)
            begin
                x = win_pan[r][c][15:0];
                y = (win_color[r][c] >> (16 * b)) & 64'hFFFF;
                if (x != pnull_reg && y != cnull_reg)
                begin
                    n++; sx += x; sy += y; sxx += x * x; sxy += x * y;
                end
            end
        if (n <= 2)
            return centre[15:0];
        num = n * sxy - sx * sy;
        den = n * sxx - sx * sx;
        if (den <= 0)
            return centre[15:0];
        clampv = clamp_reg;
        floorv = (floors_reg >> (16 * b)) & 64'hFFFF;
        att = longint'($signed(att_reg));
        mag = ((num < 0 ? -num : num) * 256 + den / 2) / den;
        slope = num < 0 ? -mag : mag;
        if (slope > clampv) slope = clampv;
        if (slope < -clampv) slope = -clampv;
        p = att * slope * diff;
        mag = ((p < 0 ? -p : p) + (64'sd1 << 19)) >>> 20;
        delta = p < 0 ? -mag : mag;
        res = centre + delta;
        if (res > 65535) res = 65535;
        if (res < floorv) res = floorv;
        return res[15:0];
    endfunction

    task automatic predict_pixel();
        int eff, used, c, idx, centre;
        logic [31:0] pan, cp;
        logic [63:0] colw;
        fused_t f;
        eff = (width_reg == 0 || width_reg > MAXW) ? MAXW : width_reg;
        used = bands_reg > 4 ? 4 : bands_reg;
        pan = {pan_high, pan_low};
        colw = {band_3, band_2, band_1, band_0};
        if (frame_start)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = col_cnt % MAXW;
        for (int r = 0; r < WIN; r++)
            for (int k = 0; k < WIN - 1; k++)
            begin
                win_pan[r][k] = win_pan[r][k + 1];
                win_color[r][k] = win_color[r][k + 1];
            end
        for (int k = 0; k < LINES; k++)
        begin
            idx = ((row_cnt + k) % LINES) * MAXW + c;
            win_pan[k][WIN - 1] = pan_store[idx];
            win_color[k][WIN - 1] = color_store[idx];
        end
        win_pan[WIN - 1][WIN - 1] = pan;
        win_color[WIN - 1][WIN - 1] = colw;
        idx = (row_cnt % LINES) * MAXW + c;
        pan_store[idx] = pan;
        color_store[idx] = colw;
        if (c >= WIN - 1 && row_cnt >= WIN - 1)
        begin
            cp = win_pan[HALF][HALF];
            f.col = 11'(c - HALF);
            f.row = 12'(row_cnt - HALF);
            for (int b = 0; b < 4; b++)
            begin
                centre = (win_color[HALF][HALF] >> (16 * b)) & 64'hFFFF;
                f.band[b] = '0;
                if (b < used)
                    f.band[b] = centre != 0 ?
                        fit_band(b, centre, longint'(cp[31:16]) - longint'(cp[15:0])) :
                        16'(centre);
                if (typed_on)
                    f.band[b] = 16'(typed_val[b]);
            end
            fused_q.push_back(f);
        end
        if (c + 1 >= eff)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1) & 12'hFFF;
        end
        else
            col_cnt = c + 1;
    endtask

    task automatic send_pixel(bit fs, int pl, int ph, int b0, int b1, int b2, int b3);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        frame_start = fs;
        pan_low = 16'(pl);
        pan_high = 16'(ph);
        band_0 = 16'(b0);
        band_1 = 16'(b1);
        band_2 = 16'(b2);
        band_3 = 16'(b3);
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel();
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (index)
            CFG_LINE_WIDTH:  width_reg = value[11:0];
            CFG_BAND_COUNT:  bands_reg = value[2:0];
            CFG_ATTENUATOR:  att_reg = value[15:0];
            CFG_SLOPE_CLAMP: clamp_reg = value[15:0];
            CFG_PAN_NULL:    pnull_reg = value[15:0];
            CFG_COLOR_NULL:  cnull_reg = value[15:0];
            CFG_BAND_FLOORS: floors_reg = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (fused_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(int w, int bc, int att, int clamp, int pn, int cn,
                            logic [63:0] fl);
        drain();
        write_reg(CFG_LINE_WIDTH, 64'(w));
        write_reg(CFG_BAND_COUNT, 64'(bc));
        write_reg(CFG_ATTENUATOR, 64'(att & 16'hFFFF));
        write_reg(CFG_SLOPE_CLAMP, 64'(clamp));
        write_reg(CFG_PAN_NULL, 64'(pn));
        write_reg(CFG_COLOR_NULL, 64'(cn));
        write_reg(CFG_BAND_FLOORS, fl);
    endtask

    // one frame; null_pct injects pan_null / color_null samples
    task automatic run_frame(pattern_t pat, int w, int pixels, int pl0, int ph0, int bv,
                             int null_pct, int break_pct);
        int x, y, pl, ph, bs [4];
        for (int i = 0; i < pixels; i++)
        begin
            x = i % w;
            y = i / w;
            pl = pl0; ph = ph0;
            for (int b = 0; b < 4; b++)
                bs[b] = bv;
            if (pat == PAT_RAMP)
            begin
                pl = (pl0 + 900 * x + 1300 * y + $urandom_range(0, 3000)) & 16'hFFFF;
                ph = (pl + $urandom_range(0, 9000) - 4500) & 16'hFFFF;
                for (int b = 0; b < 4; b++)
                    bs[b] = ((pl * (b + 1)) / 3 + $urandom_range(0, 2500)) & 16'hFFFF;
            end
            else if (pat == PAT_NOISE)
            begin
                pl = $urandom_range(0, 65535);
                ph = $urandom_range(0, 65535);
                for (int b = 0; b < 4; b++)
                    bs[b] = $urandom_range(0, 65535);
            end
            if ($urandom_range(0, 99) < null_pct)
                pl = pnull_reg;
            for (int b = 0; b < 4; b++)
                if ($urandom_range(0, 99) < null_pct)
                    bs[b] = cnull_reg;
            send_pixel(i == 0 || ($urandom_range(0, 999) < break_pct),
                       pl, ph, bs[0], bs[1], bs[2], bs[3]);
        end
        frames_run++;
    endtask

    // receiver side
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results pending", $realtime, fused_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (fused_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result col %0d row %0d", $realtime, out_col, out_row);
            end
            else
            begin
                fused_t f;
                logic [15:0] got [4];
                f = fused_q.pop_front();
                got = '{out_band_0, out_band_1, out_band_2, out_band_3};
                if (f.col !== out_col || f.row !== out_row)
                begin
                    errors++;
                    $display("%0t: position expected %0d/%0d actual %0d/%0d", $realtime,
                             f.col, f.row, out_col, out_row);
                end
                for (int b = 0; b < 4; b++)
                    if (f.band[b] !== got[b])
                    begin
                        errors++;
                        $display("%0t: band %0d at %0d/%0d expected %0d actual %0d", $realtime,
                                 b, f.col, f.row, f.band[b], got[b]);
                    end
            end
        end
    end

    dir_row_t dir_rows [] = '{
        '{8, 3, 4096, 1024, 0, 0, 64'h0, PAT_FLAT, 1000, 3000, 500, 40, 1'b1,
          '{500, 500, 500, 0}},
        '{8, 4, 32767, 65535, 0, 0, 64'h0, PAT_FLAT, 65535, 0, 65535, 40, 1'b1,
          '{65535, 65535, 65535, 65535}},
        '{8, 0, 4096, 1024, 0, 0, 64'h0, PAT_FLAT, 100, 200, 700, 40, 1'b1,
          '{0, 0, 0, 0}},
        '{8, 7, 4096, 1024, 0, 0, 64'h0, PAT_FLAT, 0, 65535, 0, 40, 1'b1,
          '{0, 0, 0, 0}},
        '{8, 4, 4096, 1024, 1000, 0, 64'h0, PAT_FLAT, 1000, 9000, 1234, 40, 1'b1,
          '{1234, 1234, 1234, 1234}},
        '{9, 4, -32768, 65535, 0, 0, 64'h0, PAT_RAMP, 0, 0, 0, 45, 1'b0,
          '{0, 0, 0, 0}},
        '{8, 4, 32767, 65535, 0, 0, 64'hFFFF_8000_4000_2000, PAT_RAMP, 0, 0, 0, 40, 1'b0,
          '{0, 0, 0, 0}},
        '{8, 4, 4096, 0, 0, 0, 64'h0, PAT_RAMP, 0, 0, 0, 40, 1'b0, '{0, 0, 0, 0}},
        '{0, 4, 4096, 1024, 0, 0, 64'h0, PAT_NOISE, 0, 0, 0, 20, 1'b0, '{0, 0, 0, 0}},
        '{4095, 4, 4096, 1024, 0, 0, 64'h0, PAT_NOISE, 0, 0, 0, 20, 1'b0, '{0, 0, 0, 0}},
        '{2048, 4, 4096, 1024, 0, 0, 64'h0, PAT_NOISE, 0, 0, 0, 20, 1'b0, '{0, 0, 0, 0}}
    };

    initial
    begin
        int w, h, nulls;
        pattern_t pat;
        logic [63:0] fl;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        foreach (dir_rows[i])
        begin
            set_regs(dir_rows[i].width, dir_rows[i].bands, dir_rows[i].att, dir_rows[i].clamp,
                     dir_rows[i].pnull, dir_rows[i].cnull, dir_rows[i].floors);
            typed_on = dir_rows[i].typed;
            typed_val = dir_rows[i].e;
            run_frame(dir_rows[i].pat, dir_rows[i].width == 9 ? 9 : 8, dir_rows[i].pixels,
                      dir_rows[i].pl, dir_rows[i].ph, dir_rows[i].bv, 0, 0);
        end
        drain();
        typed_on = 1'b0;

        for (int fr = 0; items_sent < 760; fr++)
        begin
            w = $urandom_range(0, 9) == 0 ? $urandom_range(13, 24) : $urandom_range(8, 12);
            h = $urandom_range(5, 7);
            fl = {16'($urandom_range(0, 3) == 0 ? $urandom : 0), 16'($urandom_range(0, 20000)),
                  16'($urandom_range(0, 3) == 0 ? 16'hFFFF : 0), 16'($urandom_range(0, 4000))};
            set_regs(w, $urandom_range(0, 7),
                     $urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 32767 : -32768)
                                              : int'($urandom_range(0, 16384)) - 8192,
                     $urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 65535 : 0)
                                              : $urandom_range(0, 4096),
                     $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535),
                     $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535),
                     $urandom_range(0, 1) ? 64'h0 : fl);
            quiet = items_sent > 590;
            if (fr == 2)
                hold_req = 1'b1;
            pat = $urandom_range(0, 9) < 7 ? PAT_RAMP : PAT_NOISE;
            nulls = $urandom_range(0, 2) == 0 ? $urandom_range(5, 40) : 0;
            run_frame(pat, w, w * h, $urandom_range(0, 8000), 0, 0, nulls,
                      $urandom_range(0, 5) == 0 ? 4 : 0);
        end

        drain();
        $display("Covered %0d pixels in %0d frames, %0d fused results checked.",
                 items_sent, frames_run, results_seen);
        $display("Widths, band counts, gain and clamp extremes, nulls and floors exercised.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
